// ===== rtl/core/swerve_module_angle_optimizer_macros.svh =====
// Assertion macros shared by the port checker of the swerve module angle optimizer.
`ifndef SWERVE_MODULE_ANGLE_OPTIMIZER_MACROS_SVH
`define SWERVE_MODULE_ANGLE_OPTIMIZER_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define SMA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("port check failed");

// Next-cycle implication, off while reset is high.
`define SMA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("port check failed");

// Same-cycle implication that also runs through reset.
`define SMA_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("port check failed");

`endif

// ===== rtl/core/sma_pkg.sv =====
// Shared types, constants and the cosine table of the swerve module angle optimizer.
package sma_pkg;

  localparam int WHEELS      = 4;
  localparam int COS_ENTRIES = 1024;

  localparam int ANGLE_W   = 16;
  localparam int SPD_W     = 15;
  localparam int RAD_W     = 16;
  localparam int MASK_W    = 4;
  localparam int WHEEL_W   = 2;
  localparam int COS_W     = 16;
  localparam int SPEED_W   = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam int MAG_W       = 15;
  localparam int CI_W        = $clog2(COS_ENTRIES + 1);
  localparam int SCALED_W    = MAG_W + CI_W + 1;
  localparam int PROD1_W     = SPD_W + RAD_W;
  localparam int PROD2_W     = PROD1_W + COS_W;
  localparam int ROUND_SHIFT = 23;
  localparam int ROUND_W     = PROD2_W - ROUND_SHIFT + 1;

  localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 16'sd16384;
  localparam logic [MAG_W-1:0]          MAG_LIMIT    = 15'd16384;
  localparam int                        MAG_SHIFT    = 14;
  localparam logic [SCALED_W-1:0]       MAG_HALF     = SCALED_W'(8192);

  localparam logic [SPD_W-1:0]  MIN_SPEED_RESET      = 15'd205;
  localparam logic [RAD_W-1:0]  INVERSE_RADIUS_RESET = 16'd4339;
  localparam logic [MASK_W-1:0] REVERSE_MASK_RESET   = 4'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_SPEED      = 2'd0,
    REG_INVERSE_RADIUS = 2'd1,
    REG_REVERSE_MASK   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [WHEEL_W-1:0]        wheel;
    logic signed [ANGLE_W-1:0] angle;
    logic                      neg;
    logic [CI_W-1:0]           ci;
    logic [PROD1_W-1:0]        prod;
  } lookup_t;

  typedef struct packed {
    logic [WHEEL_W-1:0]        wheel;
    logic signed [ANGLE_W-1:0] angle;
    logic                      neg;
    logic [COS_W-1:0]          cosv;
    logic [PROD1_W-1:0]        prod;
  } scale_t;

  typedef logic [COS_W-1:0] cos_rom_t [0:COS_ENTRIES];

  localparam longint CQ_C0 = 64'sd1073741824;
  localparam longint CQ_C1 = 64'sd1324675879;
  localparam longint CQ_C2 = 64'sd272375560;
  localparam longint CQ_C3 = 64'sd22401998;
  localparam longint CQ_C4 = 64'sd987052;

  localparam longint unsigned COS_N2 =
    64'(COS_ENTRIES) * 64'(COS_ENTRIES);

  function automatic longint mul_q30(longint a, longint unsigned u);
    logic            neg;
    longint unsigned mag;
    longint unsigned p;
    neg = (a < 0);
    mag = neg ? longint'(-a) : longint'(a);
    p   = (mag * u + (64'd1 << 29)) >> 30;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic cos_rom_t build_cos();
    cos_rom_t        tab;
    longint unsigned u;
    longint unsigned r;
    longint          acc;
    for (int k = 0; k <= COS_ENTRIES; k++) begin
      u   = (((64'(k) * 64'(k)) << 30) + COS_N2 / 2) / COS_N2;
      acc = CQ_C4;
      acc = -CQ_C3 + mul_q30(acc, u);
      acc = CQ_C2 + mul_q30(acc, u);
      acc = -CQ_C1 + mul_q30(acc, u);
      acc = CQ_C0 + mul_q30(acc, u);
      if (acc <= 0) begin
        tab[k] = '0;
      end else begin
        r = (longint'(acc) + (64'd1 << 14)) >> 15;
        tab[k] = (r > 64'd32768) ? COS_W'(32768) : COS_W'(r);
      end
    end
    return tab;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos();

endpackage

// ===== rtl/core/sma_steer.sv =====
// Steering decision, angle error to table index, and speed times inverse radius.
module sma_steer (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     item_valid,
  output logic                                     item_ready,
  input  logic [sma_pkg::WHEEL_W-1:0]              wheel_index,
  input  logic signed [sma_pkg::ANGLE_W-1:0]       target_angle,
  input  logic signed [sma_pkg::ANGLE_W-1:0]       target_speed,
  input  logic signed [sma_pkg::ANGLE_W-1:0]       measured_angle,
  input  logic [sma_pkg::SPD_W-1:0]                min_speed,
  input  logic [sma_pkg::RAD_W-1:0]                inverse_radius,
  input  logic [sma_pkg::MASK_W-1:0]               reverse_mask,
  output logic                                     down_valid,
  input  logic                                     down_ready,
  output sma_pkg::lookup_t                         down
);

  logic                                a_valid;
  logic [sma_pkg::WHEEL_W-1:0]         a_wheel;
  logic signed [sma_pkg::ANGLE_W-1:0]  a_angle;
  logic signed [sma_pkg::ANGLE_W-1:0]  a_meas;
  logic [sma_pkg::SPD_W-1:0]           a_speed;
  logic                                a_neg;

  logic                                b_valid;
  sma_pkg::lookup_t                    b;
  sma_pkg::lookup_t                    b_next;

  logic                                en_a;
  logic                                en_b;

  logic                                stop;
  logic                                flip;
  logic                                rev;
  logic signed [sma_pkg::ANGLE_W-1:0]  diff;
  logic signed [sma_pkg::ANGLE_W-1:0]  ang;

  logic signed [sma_pkg::ANGLE_W-1:0]  err;
  logic [sma_pkg::ANGLE_W-1:0]         err_abs;
  logic [sma_pkg::MAG_W-1:0]           mag;
  logic [sma_pkg::SCALED_W-1:0]        scaled;

  assign en_b       = !b_valid || down_ready;
  assign en_a       = !a_valid || en_b;
  assign item_ready = en_a;
  assign down_valid = b_valid;
  assign down       = b;

  always_comb begin
    stop = $signed(target_speed) < $signed({1'b0, min_speed});
    diff = target_angle - measured_angle;
    flip = (diff > sma_pkg::QUARTER_TURN) || (diff < -sma_pkg::QUARTER_TURN);
    ang  = flip ? {~target_angle[sma_pkg::ANGLE_W-1], target_angle[sma_pkg::ANGLE_W-2:0]}
                : target_angle;
    rev  = (32'(wheel_index) < sma_pkg::WHEELS) && reverse_mask[wheel_index];
  end

  always_comb begin
    err     = a_angle - a_meas;
    err_abs = err[sma_pkg::ANGLE_W-1] ? 16'(-err) : 16'(err);
    mag     = (err_abs > 16'(sma_pkg::MAG_LIMIT)) ? sma_pkg::MAG_LIMIT
                                                  : err_abs[sma_pkg::MAG_W-1:0];
    scaled  = sma_pkg::SCALED_W'(mag) * sma_pkg::SCALED_W'(sma_pkg::COS_ENTRIES)
              + sma_pkg::MAG_HALF;
    b_next.wheel = a_wheel;
    b_next.angle = a_angle;
    b_next.neg   = a_neg;
    b_next.ci    = sma_pkg::CI_W'(scaled >> sma_pkg::MAG_SHIFT);
    b_next.prod  = sma_pkg::PROD1_W'(a_speed) * sma_pkg::PROD1_W'(inverse_radius);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (en_a) begin
        a_valid <= item_valid;
      end
      if (en_b) begin
        b_valid <= a_valid;
      end
    end
  end

  // hold the measured angle and drop the speed below the threshold
  always_ff @(posedge clk) begin
    if (en_a && item_valid) begin
      a_wheel <= wheel_index;
      a_meas  <= measured_angle;
      a_angle <= stop ? measured_angle : ang;
      a_speed <= stop ? '0 : target_speed[sma_pkg::SPD_W-1:0];
      a_neg   <= flip ^ rev;
    end
    if (en_b && a_valid) begin
      b <= b_next;
    end
  end

endmodule

// ===== rtl/core/sma_cos.sv =====
// Registered cosine table lookup stage.
module sma_cos (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  sma_pkg::lookup_t up,
  output logic             down_valid,
  input  logic             down_ready,
  output sma_pkg::scale_t  down
);

  logic            c_valid;
  sma_pkg::scale_t c;
  logic            en_c;

  assign en_c       = !c_valid || down_ready;
  assign up_ready   = en_c;
  assign down_valid = c_valid;
  assign down       = c;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en_c) begin
      c_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c && up_valid) begin
      c.wheel <= up.wheel;
      c.angle <= up.angle;
      c.neg   <= up.neg;
      c.prod  <= up.prod;
      c.cosv  <= sma_pkg::COS_ROM[up.ci];
    end
  end

endmodule

// ===== rtl/core/sma_speed.sv =====
// Cosine scaling, rounding and saturation of the speed command.
module sma_speed (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               up_valid,
  output logic                               up_ready,
  input  sma_pkg::scale_t                    up,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic [sma_pkg::WHEEL_W-1:0]        wheel_out,
  output logic signed [sma_pkg::ANGLE_W-1:0] angle_cmd,
  output logic signed [sma_pkg::SPEED_W-1:0] speed_cmd
);

  localparam logic [sma_pkg::ROUND_W-1:0] POS_LIMIT =
    sma_pkg::ROUND_W'((64'd1 << (sma_pkg::SPEED_W - 1)) - 64'd1);
  localparam logic [sma_pkg::ROUND_W-1:0] NEG_LIMIT =
    sma_pkg::ROUND_W'(64'd1 << (sma_pkg::SPEED_W - 1));
  localparam logic [sma_pkg::PROD2_W:0] ROUND_HALF =
    (sma_pkg::PROD2_W + 1)'(64'd1 << (sma_pkg::ROUND_SHIFT - 1));

  logic                               d_valid;
  logic [sma_pkg::WHEEL_W-1:0]        d_wheel;
  logic signed [sma_pkg::ANGLE_W-1:0] d_angle;
  logic                               d_neg;
  logic [sma_pkg::PROD2_W-1:0]        d_prod;

  logic                               en_d;
  logic                               en_e;

  logic [sma_pkg::PROD2_W:0]          rounded;
  logic [sma_pkg::ROUND_W-1:0]        m;
  logic signed [sma_pkg::SPEED_W-1:0] speed_next;

  assign en_e     = !result_valid || result_ready;
  assign en_d     = !d_valid || en_e;
  assign up_ready = en_d;

  always_comb begin
    rounded = (sma_pkg::PROD2_W + 1)'(d_prod) + ROUND_HALF;
    m       = rounded[sma_pkg::PROD2_W:sma_pkg::ROUND_SHIFT];
    if (d_neg) begin
      speed_next = (m > NEG_LIMIT) ? sma_pkg::SPEED_W'(NEG_LIMIT)
                                   : sma_pkg::SPEED_W'(-m);
    end else begin
      speed_next = (m > POS_LIMIT) ? sma_pkg::SPEED_W'(POS_LIMIT)
                                   : sma_pkg::SPEED_W'(m);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en_d) begin
        d_valid <= up_valid;
      end
      if (en_e) begin
        result_valid <= d_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_d && up_valid) begin
      d_wheel <= up.wheel;
      d_angle <= up.angle;
      d_neg   <= up.neg;
      d_prod  <= sma_pkg::PROD2_W'(up.prod) * sma_pkg::PROD2_W'(up.cosv);
    end
    if (en_e && d_valid) begin
      wheel_out <= d_wheel;
      angle_cmd <= d_angle;
      speed_cmd <= speed_next;
    end
  end

endmodule

// ===== rtl/core/swerve_module_angle_optimizer.sv =====
// Top level of the swerve module angle optimizer: config registers and pipeline.
// Each item passes the five stages in order and is held back while results stall.
// Throughput: one item per cycle unless results stall; each stage has a valid bit.
// The cosine table read and the two multipliers each take one stage.
// Reset clears all valid bits and loads the config registers with their defaults.
module swerve_module_angle_optimizer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sma_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sma_pkg::CFG_DAT_W-1:0]        cfg_data,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  logic [sma_pkg::WHEEL_W-1:0]          wheel_index,
  input  logic signed [sma_pkg::ANGLE_W-1:0]   target_angle,
  input  logic signed [sma_pkg::ANGLE_W-1:0]   target_speed,
  input  logic signed [sma_pkg::ANGLE_W-1:0]   measured_angle,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic [sma_pkg::WHEEL_W-1:0]          wheel_out,
  output logic signed [sma_pkg::ANGLE_W-1:0]   angle_cmd,
  output logic signed [sma_pkg::SPEED_W-1:0]   speed_cmd
);

  logic [sma_pkg::SPD_W-1:0]  min_speed;
  logic [sma_pkg::RAD_W-1:0]  inverse_radius;
  logic [sma_pkg::MASK_W-1:0] reverse_mask;

  logic             lookup_valid;
  logic             lookup_ready;
  sma_pkg::lookup_t lookup;
  logic             scale_valid;
  logic             scale_ready;
  sma_pkg::scale_t  scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_speed      <= sma_pkg::MIN_SPEED_RESET;
      inverse_radius <= sma_pkg::INVERSE_RADIUS_RESET;
      reverse_mask   <= sma_pkg::REVERSE_MASK_RESET;
    end else if (cfg_valid) begin
      case (sma_pkg::cfg_reg_t'(cfg_index))
        sma_pkg::REG_MIN_SPEED: begin
          min_speed <= cfg_data[sma_pkg::SPD_W-1:0];
        end
        sma_pkg::REG_INVERSE_RADIUS: begin
          inverse_radius <= cfg_data[sma_pkg::RAD_W-1:0];
        end
        sma_pkg::REG_REVERSE_MASK: begin
          reverse_mask <= cfg_data[sma_pkg::MASK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  sma_steer u_steer (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .wheel_index    (wheel_index),
    .target_angle   (target_angle),
    .target_speed   (target_speed),
    .measured_angle (measured_angle),
    .min_speed      (min_speed),
    .inverse_radius (inverse_radius),
    .reverse_mask   (reverse_mask),
    .down_valid     (lookup_valid),
    .down_ready     (lookup_ready),
    .down           (lookup)
  );

  sma_cos u_cos (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (lookup_valid),
    .up_ready   (lookup_ready),
    .up         (lookup),
    .down_valid (scale_valid),
    .down_ready (scale_ready),
    .down       (scale)
  );

  sma_speed u_speed (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (scale_valid),
    .up_ready     (scale_ready),
    .up           (scale),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .wheel_out    (wheel_out),
    .angle_cmd    (angle_cmd),
    .speed_cmd    (speed_cmd)
  );

endmodule

// ===== rtl/core/sma_port_checker.sv =====
// Port-level checks of the swerve module angle optimizer, bound to the top level.
`include "swerve_module_angle_optimizer_macros.svh"

module sma_port_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready,
  input logic [sma_pkg::CFG_IDX_W-1:0]        cfg_index,
  input logic [sma_pkg::CFG_DAT_W-1:0]        cfg_data,
  input logic                                 item_valid,
  input logic                                 item_ready,
  input logic [sma_pkg::WHEEL_W-1:0]          wheel_index,
  input logic signed [sma_pkg::ANGLE_W-1:0]   target_angle,
  input logic signed [sma_pkg::ANGLE_W-1:0]   target_speed,
  input logic signed [sma_pkg::ANGLE_W-1:0]   measured_angle,
  input logic                                 result_valid,
  input logic                                 result_ready,
  input logic [sma_pkg::WHEEL_W-1:0]          wheel_out,
  input logic signed [sma_pkg::ANGLE_W-1:0]   angle_cmd,
  input logic signed [sma_pkg::SPEED_W-1:0]   speed_cmd
);

  logic item_seen;
  logic cfg_seen;

  assign item_seen = item_valid && (wheel_index == wheel_index) &&
                     (target_angle == target_angle) && (target_speed == target_speed) &&
                     (measured_angle == measured_angle);
  assign cfg_seen  = cfg_valid && (cfg_index == cfg_index) && (cfg_data == cfg_data);

  // stalled result holds its payload
  `SMA_ASSERT_NXT(a_result_hold, result_valid && !result_ready,
                  result_valid && $stable(wheel_out) && $stable(angle_cmd) &&
                  $stable(speed_cmd))

  // config writes never wait
  `SMA_ASSERT_IMP(a_cfg_ready, cfg_seen, cfg_ready)

  // input stalls only when every stage is full behind a blocked result
  `SMA_ASSERT_IMP(a_stall_source, !item_ready || (item_seen && !item_ready), result_valid && !result_ready)

  // pipeline is empty right after reset
  `SMA_ASSERT_RST(a_reset_empty, $past(rst) && !rst, !result_valid)

endmodule

bind swerve_module_angle_optimizer sma_port_checker u_port_checker (.*);

// ===== tb/sv/sma_cmd_checker.sv =====
`timescale 1ns / 100ps
// Checker for the swerve module angle optimizer: tracks config, predicts and compares commands.
module sma_cmd_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [sma_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sma_pkg::CFG_DAT_W-1:0]        cfg_data,
  input  logic                                 item_valid,
  input  logic                                 item_ready,
  input  logic [sma_pkg::WHEEL_W-1:0]          wheel_index,
  input  logic signed [sma_pkg::ANGLE_W-1:0]   target_angle,
  input  logic signed [sma_pkg::ANGLE_W-1:0]   target_speed,
  input  logic signed [sma_pkg::ANGLE_W-1:0]   measured_angle,
  input  logic                                 result_valid,
  input  logic                                 result_ready,
  input  logic [sma_pkg::WHEEL_W-1:0]          wheel_out,
  input  logic signed [sma_pkg::ANGLE_W-1:0]   angle_cmd,
  input  logic signed [sma_pkg::SPEED_W-1:0]   speed_cmd,
  output int                                   fail_count,
  output int                                   pending
);
  import sma_pkg::*;

  localparam logic [SPD_W-1:0]  MIN_SPEED_INIT = 15'd205;
  localparam logic [RAD_W-1:0]  INV_RADIUS_INIT = 16'd4339;
  localparam logic [MASK_W-1:0] REV_MASK_INIT = 4'd6;

  localparam int     QUARTER     = 16384;
  localparam int     MAX_REPORTS = 10;
  localparam longint SPEED_POS_MAX = 64'sd8388607;
  localparam longint SPEED_NEG_MAG = 64'sd8388608;

  localparam longint HORNER_C0 = 64'sd1073741824;
  localparam longint HORNER_C1 = 64'sd1324675879;
  localparam longint HORNER_C2 = 64'sd272375560;
  localparam longint HORNER_C3 = 64'sd22401998;
  localparam longint HORNER_C4 = 64'sd987052;

  typedef struct packed {
    logic [WHEEL_W-1:0]        wheel;
    logic signed [ANGLE_W-1:0] angle;
    logic signed [SPEED_W-1:0] speed;
  } wheel_cmd_t;

  logic [15:0]       cos_q15 [0:COS_ENTRIES];
  logic [SPD_W-1:0]  min_spd;
  logic [RAD_W-1:0]  inv_rad;
  logic [MASK_W-1:0] rev_mask;
  wheel_cmd_t        cmd_q [$];
  int                fails = 0;

  assign fail_count = fails;

  function automatic longint q30_scale(longint a, longint unsigned u);
    longint unsigned mag;
    longint unsigned p;
    mag = (a < 0) ? -a : a;
    p   = (mag * u + (64'd1 << 29)) >> 30;
    return (a < 0) ? -$signed(p) : $signed(p);
  endfunction

  initial begin : build_cos_table
    longint unsigned n2;
    longint unsigned kk;
    longint unsigned u;
    longint unsigned r;
    longint          acc;
    n2 = 64'(COS_ENTRIES) * 64'(COS_ENTRIES);
    for (int k = 0; k <= COS_ENTRIES; k++) begin
      kk  = 64'(k);
      u   = (((kk * kk) << 30) + n2 / 2) / n2;
      acc = HORNER_C4;
      acc = q30_scale(acc, u) - HORNER_C3;
      acc = q30_scale(acc, u) + HORNER_C2;
      acc = q30_scale(acc, u) - HORNER_C1;
      acc = q30_scale(acc, u) + HORNER_C0;
      if (acc <= 0) begin
        cos_q15[k] = '0;
      end else begin
        r = acc;
        r = (r + 64'd16384) >> 15;
        cos_q15[k] = (r > 64'd32768) ? 16'd32768 : 16'(r);
      end
    end
  end

  function automatic wheel_cmd_t steer_command(logic [WHEEL_W-1:0] w,
                                               logic signed [ANGLE_W-1:0] tgt,
                                               logic signed [ANGLE_W-1:0] spd,
                                               logic signed [ANGLE_W-1:0] meas);
    wheel_cmd_t                c;
    logic signed [ANGLE_W-1:0] diff;
    logic signed [ANGLE_W-1:0] err;
    logic signed [ANGLE_W-1:0] ang;
    logic                      flip;
    logic                      neg;
    int                        mag;
    int                        idx;
    longint unsigned           m;
    longint                    s;
    c.wheel = w;
    c.angle = meas;
    c.speed = '0;
    if (int'(spd) >= int'(min_spd)) begin
      diff = tgt - meas;
      flip = (diff > QUARTER) || (diff < -QUARTER);
      ang  = tgt;
      if (flip) ang[ANGLE_W-1] = ~ang[ANGLE_W-1];
      neg  = flip ^ rev_mask[w];
      err  = ang - meas;
      mag  = (err < 0) ? -int'(err) : int'(err);
      if (mag > QUARTER) mag = QUARTER;
      idx  = (mag * COS_ENTRIES + QUARTER / 2) / QUARTER;
      if (idx > COS_ENTRIES) idx = COS_ENTRIES;
      m    = 64'(spd);
      m    = m * inv_rad * cos_q15[idx];
      m    = (m + (64'd1 << 22)) >> 23;
      if (neg) s = ($signed(m) > SPEED_NEG_MAG) ? -SPEED_NEG_MAG : -$signed(m);
      else     s = ($signed(m) > SPEED_POS_MAX) ? SPEED_POS_MAX : $signed(m);
      c.angle = ang;
      c.speed = SPEED_W'(s);
    end
    return c;
  endfunction

  always @(posedge clk) begin : monitor
    wheel_cmd_t seen;
    wheel_cmd_t want;
    if (rst) begin
      min_spd  <= MIN_SPEED_INIT;
      inv_rad  <= INV_RADIUS_INIT;
      rev_mask <= REV_MASK_INIT;
      cmd_q.delete();
      pending  <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_SPEED:      min_spd  <= cfg_data[SPD_W-1:0];
          REG_INVERSE_RADIUS: inv_rad  <= cfg_data[RAD_W-1:0];
          REG_REVERSE_MASK:   rev_mask <= cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end
      if (item_valid && item_ready)
        cmd_q.push_back(steer_command(wheel_index, target_angle, target_speed,
                                      measured_angle));
      if (result_valid && result_ready) begin
        seen.wheel = wheel_out;
        seen.angle = angle_cmd;
        seen.speed = speed_cmd;
        if (cmd_q.size() == 0) begin
          if (fails < MAX_REPORTS)
            $display("unexpected command: wheel %0d angle %0d speed %0d",
                     seen.wheel, seen.angle, seen.speed);
          fails++;
        end else begin
          want = cmd_q.pop_front();
          if (seen.wheel !== want.wheel || seen.angle !== want.angle ||
              seen.speed !== want.speed) begin
            if (fails < MAX_REPORTS)
              $display("command mismatch: wheel %0d/%0d angle %0d/%0d speed %0d/%0d (exp/act)",
                       want.wheel, seen.wheel, want.angle, seen.angle,
                       want.speed, seen.speed);
            fails++;
          end
        end
      end
      pending <= cmd_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the swerve module angle optimizer: clock, reset, stimulus and verdict.
module tb_top;
  import sma_pkg::*;

  localparam int                     SETTLE_CYCLES = 16;
  localparam longint                 RUN_LIMIT_NS  = 2_000_000;
  localparam logic [CFG_IDX_W-1:0]   REG_SPARE     = 2'd3;

  logic                        clk            = 1'b0;
  logic                        rst            = 1'b1;
  logic                        cfg_valid      = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index      = '0;
  logic [CFG_DAT_W-1:0]        cfg_data       = '0;
  logic                        item_valid     = 1'b0;
  logic                        item_ready;
  logic [WHEEL_W-1:0]          wheel_index    = '0;
  logic signed [ANGLE_W-1:0]   target_angle   = '0;
  logic signed [ANGLE_W-1:0]   target_speed   = '0;
  logic signed [ANGLE_W-1:0]   measured_angle = '0;
  logic                        result_valid;
  logic                        result_ready   = 1'b0;
  logic [WHEEL_W-1:0]          wheel_out;
  logic signed [ANGLE_W-1:0]   angle_cmd;
  logic signed [SPEED_W-1:0]   speed_cmd;

  int fail_count;
  int pending;
  int gap_pct   = 0;
  int stall_pct = 0;
  int min_set   = 205;

  swerve_module_angle_optimizer dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .wheel_index    (wheel_index),
    .target_angle   (target_angle),
    .target_speed   (target_speed),
    .measured_angle (measured_angle),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .wheel_out      (wheel_out),
    .angle_cmd      (angle_cmd),
    .speed_cmd      (speed_cmd)
  );

  sma_cmd_checker chk (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .wheel_index    (wheel_index),
    .target_angle   (target_angle),
    .target_speed   (target_speed),
    .measured_angle (measured_angle),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .wheel_out      (wheel_out),
    .angle_cmd      (angle_cmd),
    .speed_cmd      (speed_cmd),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] ms, input logic [15:0] inv, input logic [15:0] mask);
    write_reg(REG_MIN_SPEED, ms);
    write_reg(REG_INVERSE_RADIUS, inv);
    write_reg(REG_REVERSE_MASK, mask);
    cfg_valid <= 1'b0;
    min_set = int'(ms[14:0]);
  endtask

  task automatic send_item(input logic [WHEEL_W-1:0] w, input logic signed [ANGLE_W-1:0] tgt,
                           input logic signed [ANGLE_W-1:0] spd,
                           input logic signed [ANGLE_W-1:0] meas);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    item_valid     <= 1'b1;
    wheel_index    <= w;
    target_angle   <= tgt;
    target_speed   <= spd;
    measured_angle <= meas;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic send_random(input int n);
    logic [15:0] meas;
    logic [15:0] tgt;
    int          off;
    int          spd;
    int          r;
    for (int i = 0; i < n; i++) begin
      meas = 16'($urandom);
      r = $urandom_range(99);
      if (r < 30)      off = $urandom;
      else if (r < 45) off = 16384 + int'($urandom_range(4)) - 2;
      else if (r < 60) off = -16384 + int'($urandom_range(4)) - 2;
      else if (r < 70) off = 32768 + int'($urandom_range(4)) - 2;
      else if (r < 85) off = int'($urandom_range(400)) - 200;
      else             off = int'($urandom_range(16384)) - 8192;
      tgt = meas + off[15:0];
      r = $urandom_range(99);
      if (r < 10)      spd = $urandom;
      else if (r < 16) spd = min_set - int'($urandom_range(1));
      else if (r < 22) spd = 32767;
      else             spd = $urandom_range(32767, min_set);
      send_item(WHEEL_W'($urandom), tgt, spd[15:0], meas);
    end
  endtask

  // hold off new items until every command is back
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_item(0, 0, -16'sd32768, 1234);
    send_item(1, 1000, 204, -1000);
    send_item(2, 1000, 205, 1000);
    send_item(3, 100, 32767, 100);
    send_item(0, 16384, 32767, 0);
    send_item(1, -16384, 32767, 0);
    send_item(2, 16385, 32767, 0);
    send_item(3, -16385, 32767, 0);
    send_item(0, -16'sd32768, 32767, 0);
    send_item(1, 32767, 32767, -16'sd32768);
    send_item(2, -16'sd32768, 32767, 32767);
    send_item(3, 32767, 20000, 32767);
    send_item(1, 8192, 4096, 0);
    send_item(2, -8192, 4096, 0);
    send_item(3, 24576, 4096, 0);
    send_item(0, 0, 0, 0);
    send_item(1, 0, -1, 0);
    drain();

    configure(16'd0, 16'hFFFF, 16'h000F);
    send_item(0, 0, 32767, 0);
    send_item(1, -16'sd32768, 32767, 0);
    send_item(2, 100, 0, 0);
    send_item(3, 0, -1, 500);
    send_random(100);
    drain();

    gap_pct = 50;
    configure(16'hFFFF, 16'd0, 16'h0000);
    send_random(40);
    drain();

    write_reg(REG_SPARE, 16'($urandom));
    configure(16'($urandom_range(2047)), 16'($urandom), 16'($urandom));
    send_random(100);
    drain();

    gap_pct = 0;
    stall_pct <= 50;
    configure(16'($urandom_range(2047)), 16'($urandom), 16'($urandom));
    send_random(150);
    drain();

    gap_pct = 6;
    stall_pct <= 6;
    configure(16'd205, 16'd4339, 16'h0006);
    send_random(150);
    drain();

    gap_pct = 0;
    stall_pct <= 0;
    configure(16'd1, 16'd1, 16'h0005);
    send_random(60);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
